FILE: design/akst_pkg.sv
// Package: sizes, codes and control types of the address keyed session table.
`timescale 1ns / 1ps
package akst_pkg;

	localparam int TABLE_SLOTS = 64;
	localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int ADDR_W = 32;
	localparam int TIME_W = 32;
	localparam int HIT_W = 32;
	localparam int FREE_W = 6;
	localparam int IDX_OUT_W = 6;
	localparam int STATUS_W = 3;

	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND = 3'd0,
		ST_ALLOCATED = 3'd1,
		ST_FULL = 3'd2,
		ST_DELETED = 3'd3,
		ST_EMPTY = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESOLVE,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic scan;
		logic resolve;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

FILE: design/akst_in_if.sv
// Interface: request channel carrying one table event per transfer.
`timescale 1ns / 1ps
interface akst_in_if;
	logic valid;
	logic ready;
	logic opcode;
	logic [31:0] peer_address;
	logic [5:0] free_slot;
	logic [31:0] now_seconds;

	modport source (output valid, opcode, peer_address, free_slot, now_seconds, input ready);
	modport sink (input valid, opcode, peer_address, free_slot, now_seconds, output ready);
endinterface

FILE: design/akst_out_if.sv
// Interface: response channel carrying one result per transfer.
`timescale 1ns / 1ps
interface akst_out_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [5:0] slot_index;
	logic [31:0] hit_count;

	modport source (output valid, status, slot_index, hit_count, input ready);
	modport sink (input valid, status, slot_index, hit_count, output ready);
endinterface

FILE: design/akst_ctrl.sv
// Controller: sequences capture, scan, resolve and finish of one event.
`timescale 1ns / 1ps
module akst_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  akst_pkg::sts_t sts,
	output akst_pkg::cmd_t cmd
);

	akst_pkg::state_t state_q;
	akst_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= akst_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			akst_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = akst_pkg::S_SCAN;
				end
			end
			akst_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
				state_d = akst_pkg::S_RESOLVE;
			end
			akst_pkg::S_RESOLVE: begin
				cmd.resolve = 1'b1;
				state_d = akst_pkg::S_FINISH;
			end
			akst_pkg::S_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d = akst_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = akst_pkg::S_IDLE;
			end
		endcase
	end

endmodule

FILE: design/akst_dp.sv
// Datapath: address match array, valid bits, hit and time stores, result register.
`timescale 1ns / 1ps
module akst_dp (
	input  logic clk,
	input  logic arst_n,
	input  akst_pkg::cmd_t cmd,
	output akst_pkg::sts_t sts,
	input  logic opcode,
	input  logic [akst_pkg::ADDR_W-1:0] peer_address,
	input  logic [akst_pkg::FREE_W-1:0] free_slot,
	input  logic [akst_pkg::TIME_W-1:0] now_seconds,
	output logic out_valid,
	input  logic out_ready,
	output logic [akst_pkg::STATUS_W-1:0] status,
	output logic [akst_pkg::IDX_OUT_W-1:0] slot_index,
	output logic [akst_pkg::HIT_W-1:0] hit_count
);

	localparam int N = akst_pkg::TABLE_SLOTS;
	localparam int SW = akst_pkg::SLOT_W;
	localparam logic [akst_pkg::HIT_W-1:0] HIT_ONE = akst_pkg::HIT_W'(1);

	// captured request
	logic op_q;
	logic [akst_pkg::ADDR_W-1:0] addr_q;
	logic [akst_pkg::FREE_W-1:0] victim_q;
	logic [akst_pkg::TIME_W-1:0] now_q;

	// table state
	logic [N-1:0] valid_q;
	logic [akst_pkg::ADDR_W-1:0] cam_q [N];
	logic [akst_pkg::HIT_W-1:0] hits_mem [N];
	logic [akst_pkg::TIME_W-1:0] time_mem [N];
	logic [akst_pkg::HIT_W-1:0] hits_rd_q;

	// scan results
	logic [N-1:0] match_q;
	logic [N-1:0] free_q;

	// resolved outcome
	akst_pkg::status_t res_status_q;
	logic [SW-1:0] res_slot_q;

	logic hit_any;
	logic free_any;
	logic [SW-1:0] hit_idx;
	logic [SW-1:0] free_idx;
	logic [SW-1:0] victim_idx;
	logic victim_ok;
	akst_pkg::status_t res_status_d;
	logic [SW-1:0] res_slot_d;
	logic alloc_we;
	logic hit_re;
	logic del_we;
	logic [akst_pkg::HIT_W-1:0] hits_inc;
	logic [akst_pkg::HIT_W-1:0] hit_out;

	logic out_valid_q;
	logic [akst_pkg::STATUS_W-1:0] status_q;
	logic [akst_pkg::IDX_OUT_W-1:0] slot_q;
	logic [akst_pkg::HIT_W-1:0] hit_count_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= opcode;
			addr_q <= peer_address;
			victim_q <= free_slot;
			now_q <= now_seconds;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			for (int i = 0; i < N; i++) begin
				match_q[i] <= valid_q[i] && (cam_q[i] == addr_q);
			end
			free_q <= ~valid_q;
		end
	end

	// lowest index wins
	always_comb begin
		hit_any = |match_q;
		free_any = |free_q;
		hit_idx = '0;
		free_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				hit_idx = SW'(i);
			end
			if (free_q[i]) begin
				free_idx = SW'(i);
			end
		end
	end

	assign victim_idx = SW'(victim_q);
	assign victim_ok = (32'(victim_q) < 32'(N)) && valid_q[victim_idx];

	always_comb begin
		res_status_d = akst_pkg::ST_FULL;
		res_slot_d = '0;
		alloc_we = 1'b0;
		hit_re = 1'b0;
		del_we = 1'b0;
		if (op_q == akst_pkg::OP_DELETE) begin
			res_slot_d = victim_idx;
			if (victim_ok) begin
				res_status_d = akst_pkg::ST_DELETED;
				del_we = 1'b1;
			end else begin
				res_status_d = akst_pkg::ST_EMPTY;
			end
		end else if (hit_any) begin
			res_status_d = akst_pkg::ST_FOUND;
			res_slot_d = hit_idx;
			hit_re = 1'b1;
		end else if (free_any) begin
			res_status_d = akst_pkg::ST_ALLOCATED;
			res_slot_d = free_idx;
			alloc_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.resolve) begin
			if (alloc_we) begin
				valid_q[free_idx] <= 1'b1;
			end
			if (del_we) begin
				valid_q[victim_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resolve) begin
			res_status_q <= res_status_d;
			res_slot_q <= res_slot_d;
			if (alloc_we) begin
				cam_q[free_idx] <= addr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resolve && (alloc_we || hit_re)) begin
			time_mem[res_slot_d] <= now_q;
		end
	end

	assign hits_inc = (hits_rd_q == '1) ? hits_rd_q : hits_rd_q + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.resolve && hit_re) begin
			hits_rd_q <= hits_mem[hit_idx];
		end
		if (cmd.resolve && alloc_we) begin
			hits_mem[free_idx] <= HIT_ONE;
		end else if (cmd.finish && res_status_q == akst_pkg::ST_FOUND) begin
			hits_mem[res_slot_q] <= hits_inc;
		end
	end

	always_comb begin
		case (res_status_q)
			akst_pkg::ST_FOUND: hit_out = hits_inc;
			akst_pkg::ST_ALLOCATED: hit_out = HIT_ONE;
			default: hit_out = '0;
		endcase
	end

	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q <= res_status_q;
			slot_q <= akst_pkg::IDX_OUT_W'(res_slot_q);
			hit_count_q <= hit_out;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign slot_index = slot_q;
	assign hit_count = hit_count_q;

endmodule

FILE: design/address_keyed_session_table_top.sv
// Top level: session table keyed by a 32-bit peer address.
//
// item carries one event per transfer: a packet (look up peer_address,
// allocate the lowest free slot on a miss, stamp now_seconds, count a hit)
// or a delete of slot free_slot. result carries exactly one transfer per
// event: status, slot_index and the hit count after the update.
// The result is registered after the scan, resolve and finish states
// (capture, parallel address match, priority resolve, count update).
// Events are handled one at a time; the next item is taken as soon
// as the previous one has been loaded into the result register, so a
// result may still be waiting while the next event is in progress.
// The hit count saturates at all ones. A full table answers table full
// and leaves every entry as it was.
// Reset clears every valid bit at once, so the table starts empty with no
// clearing pass. When the receiver stalls, the result register holds its
// transfer and at most one further event completes its lookup and waits.
`timescale 1ns / 1ps
module address_keyed_session_table_top (
	input  logic clk,
	input  logic arst_n,
	akst_in_if.sink item,
	akst_out_if.source result
);

	akst_pkg::cmd_t cmd;
	akst_pkg::sts_t sts;

	akst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	akst_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.opcode       (item.opcode),
		.peer_address (item.peer_address),
		.free_slot    (item.free_slot),
		.now_seconds  (item.now_seconds),
		.out_valid    (result.valid),
		.out_ready    (result.ready),
		.status       (result.status),
		.slot_index   (result.slot_index),
		.hit_count    (result.hit_count)
	);

endmodule
